// ===== src/iss_pkg.sv =====
package iss_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned OP_W         = 3;
	localparam int unsigned POS_W        = 7;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned COUNT_W      = 7;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND     = 3'd0,
		OP_PREPEND    = 3'd1,
		OP_INSERT     = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_REMOVE     = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_INDEX = 2'd1,
		STS_EMPTY = 2'd2,
		STS_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_READ   = 2'd3
	} cell_cmd_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_cmd_t         cmd;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== src/iss_in_if.sv =====
interface iss_in_if;
	logic                            valid;
	logic                            ready;
	logic [iss_pkg::OP_W-1:0]        op;
	logic signed [iss_pkg::DATA_W-1:0] item_value;
	logic [iss_pkg::POS_W-1:0]       position;

	modport source(output valid, op, item_value, position, input ready);
	modport sink(input valid, op, item_value, position, output ready);
endinterface

// ===== src/iss_out_if.sv =====
interface iss_out_if;
	logic                              valid;
	logic                              ready;
	logic [iss_pkg::STATUS_W-1:0]      status;
	logic signed [iss_pkg::DATA_W-1:0] read_value;
	logic [iss_pkg::COUNT_W-1:0]       element_count;

	modport source(output valid, status, read_value, element_count, input ready);
	modport sink(input valid, status, read_value, element_count, output ready);
endinterface

// ===== src/iss_cell.sv =====
module iss_cell #(
	parameter int unsigned IDX_W = 6,
	parameter int unsigned INDEX = 0
) (
	input  logic                           clk,
	input  iss_pkg::cell_ctl_t             ctl,
	input  logic [IDX_W-1:0]               sel,
	input  logic [iss_pkg::DATA_W-1:0]     below,
	input  logic [iss_pkg::DATA_W-1:0]     above,
	input  logic [iss_pkg::DATA_W-1:0]     rbus_in,
	output logic [iss_pkg::DATA_W-1:0]     value,
	output logic [iss_pkg::DATA_W-1:0]     rbus
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [iss_pkg::DATA_W-1:0] value_q;
	logic [iss_pkg::DATA_W-1:0] rbus_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			iss_pkg::CELL_INSERT: begin
				// cells above the gap take their lower neighbor
				if (MY_IDX > sel) begin
					value_q <= below;
				end else if (MY_IDX == sel) begin
					value_q <= ctl.value;
				end
			end
			iss_pkg::CELL_REMOVE: begin
				if (MY_IDX >= sel) begin
					value_q <= above;
				end
			end
			iss_pkg::CELL_READ: begin
				// read bus moves one cell toward the head each cycle
				rbus_q <= (MY_IDX == sel) ? value_q : rbus_in;
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign rbus  = rbus_q;

endmodule

// ===== src/iss_ctrl.sv =====
module iss_ctrl #(
	parameter int unsigned CAPACITY = iss_pkg::CAPACITY_DEF,
	parameter int unsigned IDX_W    = 6,
	parameter int unsigned CNT_W    = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	iss_in_if.sink                     req,
	iss_out_if.source                  rsp,
	output iss_pkg::cell_ctl_t         ctl,
	output logic [IDX_W-1:0]           sel,
	input  logic [iss_pkg::DATA_W-1:0] rd_data
);

	localparam int unsigned CMP_W = (CNT_W > iss_pkg::POS_W) ? CNT_W : iss_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_LOAD = 3'b100
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       rsp_valid_q;
	logic [IDX_W-1:0]           step_q;
	logic [IDX_W-1:0]           rpos_q;
	iss_pkg::status_t           sts_q;
	logic [iss_pkg::DATA_W-1:0] rd_q;
	logic [CNT_W-1:0]           cnt_out_q;

	iss_pkg::op_t               op;
	logic                       accept;
	logic                       out_free;
	logic                       rsp_post;
	logic [CMP_W-1:0]           pos_ext;
	logic [CMP_W-1:0]           cnt_ext;
	logic [CMP_W-1:0]           cap_ext;
	logic [CMP_W-1:0]           ins_p;
	iss_pkg::status_t           sts;
	logic [CNT_W-1:0]           cnt_nxt;
	iss_pkg::cell_cmd_t         cmd;
	logic [IDX_W-1:0]           at;
	logic                       rd_go;

	assign op       = iss_pkg::op_t'(req.op);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept   = req.valid && req.ready;
	assign rsp_post = (accept && !rd_go) || (state_q == S_LOAD && out_free);
	assign pos_ext  = CMP_W'(req.position);
	assign cnt_ext  = CMP_W'(cnt_q);
	assign cap_ext  = CMP_W'(CAPACITY);

	always_comb begin
		sts     = iss_pkg::STS_OK;
		cnt_nxt = cnt_q;
		cmd     = iss_pkg::CELL_HOLD;
		at      = '0;
		rd_go   = 1'b0;
		ins_p   = pos_ext;
		if (op == iss_pkg::OP_APPEND) begin
			ins_p = cnt_ext;
		end else if (op == iss_pkg::OP_PREPEND) begin
			ins_p = '0;
		end
		unique case (op) inside
			iss_pkg::OP_APPEND, iss_pkg::OP_PREPEND, iss_pkg::OP_INSERT: begin
				// index check ahead of the full check
				if (ins_p > cnt_ext) begin
					sts = iss_pkg::STS_INDEX;
				end else if (cnt_ext >= cap_ext) begin
					sts = iss_pkg::STS_FULL;
				end else begin
					cmd     = iss_pkg::CELL_INSERT;
					at      = IDX_W'(ins_p);
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			iss_pkg::OP_POP_FRONT: begin
				if (cnt_q == '0) begin
					sts = iss_pkg::STS_EMPTY;
				end else begin
					cmd     = iss_pkg::CELL_REMOVE;
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			iss_pkg::OP_POP_BACK: begin
				if (cnt_q == '0) begin
					sts = iss_pkg::STS_EMPTY;
				end else begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			iss_pkg::OP_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					sts = iss_pkg::STS_INDEX;
				end else begin
					cmd     = iss_pkg::CELL_REMOVE;
					at      = IDX_W'(pos_ext);
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			iss_pkg::OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					sts = iss_pkg::STS_INDEX;
				end else begin
					rd_go = 1'b1;
				end
			end
			default: begin
				cnt_nxt = '0;
			end
		endcase
	end

	always_comb begin
		ctl.value = req.item_value;
		if (state_q == S_READ) begin
			ctl.cmd = iss_pkg::CELL_READ;
			sel     = rpos_q;
		end else if (accept) begin
			ctl.cmd = cmd;
			sel     = at;
		end else begin
			ctl.cmd = iss_pkg::CELL_HOLD;
			sel     = at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			step_q      <= '0;
			rpos_q      <= '0;
		end else begin
			if (rsp_post) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_nxt;
						if (rd_go) begin
							state_q <= S_READ;
							step_q  <= '0;
							rpos_q  <= IDX_W'(pos_ext);
						end
					end
				end
				S_READ: begin
					// the read pass ends once step_q has counted up to position, when the wanted word has reached the head
					if (step_q == rpos_q) begin
						state_q <= S_LOAD;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !rd_go) begin
			sts_q     <= sts;
			rd_q      <= '0;
			cnt_out_q <= cnt_nxt;
		end else if (state_q == S_LOAD && out_free) begin
			sts_q     <= iss_pkg::STS_OK;
			rd_q      <= rd_data;
			cnt_out_q <= cnt_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = sts_q;
	assign rsp.read_value    = rd_q;
	assign rsp.element_count = iss_pkg::COUNT_W'(cnt_out_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready)
		else $error("ready while a read pass is running");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !rd_go |=> rsp_valid_q && cnt_q == $past(cnt_nxt))
		else $error("single-cycle op did not post its result");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> step_q <= rpos_q)
		else $error("read pass ran past its position");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD && !rsp_valid_q |=> rsp_valid_q && state_q == S_IDLE)
		else $error("read result not posted");

endmodule

// ===== src/indexed_sequence_store.sv =====
// indexed_sequence_store: ordered row of up to CAPACITY signed 32-bit words
// with push/pop at both ends, insert/remove at a position, read and clear.
// req channel (valid/ready) carries op, item_value and position; rsp channel
// returns status, read_value and element_count, one word per request word.
// Storage is a chain of cells; insert and remove shift the row in the cycle that accepts them.
// Every op except a good read posts its result the cycle after it is accepted,
// and the next request can be taken in that same cycle while rsp is ready, so
// these ops run at one per clock unless rsp stalls.
// A read that hits walks the wanted word down the cells' read bus one cell per
// clock in S_READ, then S_LOAD copies it into the output register once that is
// free; no new request is taken until the controller is back in S_IDLE.
// Reset clears the element count and the control; cell contents are left
// undefined and are only ever read after they were written.
// A stalled rsp holds its word in the output register; req stays ready while
// that register drains in the same cycle, otherwise it waits.
module indexed_sequence_store #(
	parameter int unsigned CAPACITY = iss_pkg::CAPACITY_DEF
) (
	input logic     clk,
	input logic     arst_n,
	iss_in_if.sink  req,
	iss_out_if.source rsp
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	iss_pkg::cell_ctl_t          ctl;
	logic [IDX_W-1:0]            sel;
	logic [iss_pkg::DATA_W-1:0]  cell_val  [CAPACITY];
	logic [iss_pkg::DATA_W-1:0]  cell_rbus [CAPACITY];

	iss_ctrl #(
		.CAPACITY(CAPACITY),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.ctl(ctl),
		.sel(sel),
		.rd_data(cell_rbus[0])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [iss_pkg::DATA_W-1:0] below;
		logic [iss_pkg::DATA_W-1:0] above;
		logic [iss_pkg::DATA_W-1:0] rin;

		if (i == 0) begin : g_head
			assign below = '0;
		end else begin : g_mid_lo
			assign below = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign above = '0;
			assign rin   = '0;
		end else begin : g_mid_hi
			assign above = cell_val[i+1];
			assign rin   = cell_rbus[i+1];
		end

		iss_cell #(
			.IDX_W(IDX_W),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.sel(sel),
			.below(below),
			.above(above),
			.rbus_in(rin),
			.value(cell_val[i]),
			.rbus(cell_rbus[i])
		);
	end

endmodule
